[rtl/core/fcmc_pkg.sv]
package fcmc_pkg;

  // Input word kinds
  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_TEMP  = 3'd1,
    KIND_LEVEL = 3'd2,
    KIND_SUPER = 3'd3,
    KIND_LOCK  = 3'd4
  } kind_t;

  // Compressor phases
  typedef enum logic [1:0] {
    PH_STOP = 2'd0,
    PH_WAIT = 2'd1,
    PH_RUN  = 2'd2
  } phase_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ON_THR    = 2'd0,
    CFG_HOUR_LIM  = 2'd1,
    CFG_START_DLY = 2'd2,
    CFG_SLEEP_DLY = 2'd3
  } cfg_idx_t;

  localparam logic MODE_SUPER = 1'b0;
  localparam logic MODE_LEVEL = 1'b1;

  localparam logic [5:0] MINUTE_SECS = 6'd60;
  localparam logic [1:0] HOLD_TOGGLE = 2'd3;
  localparam logic [2:0] LEVEL_MIN   = 3'd1;
  localparam logic [2:0] LEVEL_MAX   = 3'd5;
  localparam logic [2:0] LEVEL_RST   = 3'd3;

  localparam logic [7:0] IND_SC_LOCKED   = 8'h06;
  localparam logic [7:0] IND_SC_UNLOCKED = 8'h05;

  localparam logic [6:0] ON_THR_RST    = 7'd4;
  localparam logic [7:0] HOUR_LIM_RST  = 8'd8;
  localparam logic [9:0] START_DLY_RST = 10'd20;
  localparam logic [9:0] SLEEP_DLY_RST = 10'd30;

  typedef struct packed {
    logic [6:0] on_thr;
    logic [7:0] hour_lim;
    logic [9:0] start_dly;
    logic [9:0] sleep_dly;
  } cfg_t;

  typedef struct packed {
    logic       mode;
    logic [2:0] level;
    logic       lock;
    logic       want;
    phase_t     phase;
    logic       drive;
    logic [9:0] delay_left;
    logic [9:0] sleep_left;
    logic [5:0] sec_to_min;
    logic [5:0] sc_min;
    logic [7:0] sc_hours;
    logic [1:0] hold;
    logic [7:0] last_temp;
  } state_t;

  localparam state_t ST_RST = '{
    mode:       MODE_LEVEL,
    level:      LEVEL_RST,
    lock:       1'b0,
    want:       1'b0,
    phase:      PH_STOP,
    drive:      1'b0,
    delay_left: START_DLY_RST,
    sleep_left: SLEEP_DLY_RST,
    sec_to_min: MINUTE_SECS,
    sc_min:     MINUTE_SECS,
    sc_hours:   8'd0,
    hold:       2'd0,
    last_temp:  8'd0
  };

  // Thermostat off temperature per level
  function automatic logic signed [7:0] off_temp(input logic [2:0] level);
    logic signed [7:0] t;
    case (level)
      3'd1:    t = -8'sd16;
      3'd2:    t = -8'sd18;
      3'd4:    t = -8'sd22;
      3'd5:    t = -8'sd24;
      default: t = -8'sd20;
    endcase
    return t;
  endfunction

  // LED byte for the current mode, level and lock
  function automatic logic [7:0] ind_pattern(input state_t s);
    logic [7:0] p;
    if (s.mode == MODE_SUPER) begin
      p = s.lock ? IND_SC_LOCKED : IND_SC_UNLOCKED;
    end else begin
      case (s.level)
        3'd1:    p = 8'hF3;
        3'd2:    p = 8'hEB;
        3'd4:    p = 8'hBB;
        3'd5:    p = 8'h7B;
        default: p = 8'hDB;
      endcase
      // locked variants swap the low nibble pattern
      if (s.lock) p = {p[7:4], 4'hE} & {4'hF, p[3:0] | 4'h4} | 8'h00;
    end
    return p;
  endfunction

endpackage

[rtl/core/freezer_compressor_mode_controller_core.sv]
// Channel | Direction | Words carried
// in_     | input     | kind, temperature, lock_button_down
// out_    | output    | drive, phase, mode, level, lock, display awake, LED byte
// cfg_    | input     | register index and write data, always ready
//
// One word per cycle while results are taken: an accepted word is held in the
// input register, then the event logic and two control passes update the state
// register, which is the result register. Reset is synchronous, active low, and
// restores all registers but the input data registers to defaults.
// A stalled result holds the state; one more word waits in the input register.
module freezer_compressor_mode_controller_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_kind,
  input  logic [7:0] in_temperature,
  input  logic       in_lock_button_down,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_compressor_drive,
  output logic [1:0] out_compressor_phase,
  output logic       out_cooling_mode,
  output logic [2:0] out_level_setting,
  output logic       out_lock_active,
  output logic       out_display_awake,
  output logic [7:0] out_indicator_pattern,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  fcmc_pkg::cfg_t   cfg_r;
  fcmc_pkg::state_t st_r;
  fcmc_pkg::state_t st_evt;
  fcmc_pkg::state_t st_p1;
  fcmc_pkg::state_t st_nxt;

  logic       in_vld_r;
  logic [2:0] kind_r;
  logic [7:0] temp_r;
  logic       held_r;
  logic       out_vld_r;
  logic       fire;

  // advance when the input register holds a word and the result slot frees
  assign fire     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_thr    <= fcmc_pkg::ON_THR_RST;
      cfg_r.hour_lim  <= fcmc_pkg::HOUR_LIM_RST;
      cfg_r.start_dly <= fcmc_pkg::START_DLY_RST;
      cfg_r.sleep_dly <= fcmc_pkg::SLEEP_DLY_RST;
    end else if (cfg_valid) begin
      unique case (fcmc_pkg::cfg_idx_t'(cfg_index))
        fcmc_pkg::CFG_ON_THR:    cfg_r.on_thr    <= cfg_data[6:0];
        fcmc_pkg::CFG_HOUR_LIM:  cfg_r.hour_lim  <= cfg_data[7:0];
        fcmc_pkg::CFG_START_DLY: cfg_r.start_dly <= cfg_data;
        fcmc_pkg::CFG_SLEEP_DLY: cfg_r.sleep_dly <= cfg_data;
        default:                 cfg_r           <= cfg_r;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= in_kind;
      temp_r <= in_temperature;
      held_r <= in_lock_button_down;
    end
  end

  // event handling, then two control passes
  fcmc_event u_event (
    .kind             (kind_r),
    .temperature      (temp_r),
    .lock_button_down (held_r),
    .cfg              (cfg_r),
    .st_i             (st_r),
    .st_o             (st_evt)
  );

  fcmc_ctrl u_ctrl0 (
    .cfg  (cfg_r),
    .st_i (st_evt),
    .st_o (st_p1)
  );

  fcmc_ctrl u_ctrl1 (
    .cfg  (cfg_r),
    .st_i (st_p1),
    .st_o (st_nxt)
  );

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= fcmc_pkg::ST_RST;
      out_vld_r <= 1'b0;
    end else begin
      if (fire) st_r <= st_nxt;
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid             = out_vld_r;
  assign out_compressor_drive  = st_r.drive;
  assign out_compressor_phase  = st_r.phase;
  assign out_cooling_mode      = st_r.mode;
  assign out_level_setting     = st_r.level;
  assign out_lock_active       = st_r.lock;
  assign out_display_awake     = st_r.sleep_left != 10'd0;
  assign out_indicator_pattern = fcmc_pkg::ind_pattern(st_r);

endmodule

[rtl/core/fcmc_event.sv]
module fcmc_event (
  input  logic [2:0]      kind,
  input  logic [7:0]      temperature,
  input  logic            lock_button_down,
  input  fcmc_pkg::cfg_t   cfg,
  input  fcmc_pkg::state_t st_i,
  output fcmc_pkg::state_t st_o
);

  always_comb begin
    st_o = st_i;
    case (fcmc_pkg::kind_t'(kind))
      fcmc_pkg::KIND_TICK: begin
        // count down the timers, each stopping at zero, the start delay only while waiting
        if (st_i.sleep_left != 10'd0) st_o.sleep_left = st_i.sleep_left - 10'd1;
        if (st_i.sec_to_min != 6'd0) st_o.sec_to_min = st_i.sec_to_min - 6'd1;
        if (st_i.delay_left != 10'd0 && st_i.phase == fcmc_pkg::PH_WAIT) begin
          st_o.delay_left = st_i.delay_left - 10'd1;
        end
        // advance the lock hold count, toggle on reaching the limit, clear it on release
        if (lock_button_down) begin
          if (st_i.hold != fcmc_pkg::HOLD_TOGGLE) begin
            st_o.hold = st_i.hold + 2'd1;
            if (st_i.hold + 2'd1 == fcmc_pkg::HOLD_TOGGLE) begin
              st_o.lock       = ~st_i.lock;
              st_o.sleep_left = cfg.sleep_dly;
            end
          end
        end else begin
          st_o.hold = 2'd0;
        end
      end
      fcmc_pkg::KIND_TEMP: begin
        st_o.last_temp = temperature;
      end
      fcmc_pkg::KIND_LEVEL, fcmc_pkg::KIND_SUPER: begin
        if (st_i.sleep_left == 10'd0) begin
          st_o.sleep_left = cfg.sleep_dly;
        end else if (!st_i.lock) begin
          st_o.sleep_left = cfg.sleep_dly;
          if (st_i.mode == fcmc_pkg::MODE_SUPER) begin
            st_o.mode     = fcmc_pkg::MODE_LEVEL;
            st_o.sc_min   = fcmc_pkg::MINUTE_SECS;
            st_o.sc_hours = 8'd0;
          end else if (kind == fcmc_pkg::KIND_LEVEL) begin
            st_o.level = (st_i.level >= fcmc_pkg::LEVEL_MAX) ? fcmc_pkg::LEVEL_MIN
                                                              : st_i.level + 3'd1;
          end else begin
            st_o.mode     = fcmc_pkg::MODE_SUPER;
            st_o.sc_min   = fcmc_pkg::MINUTE_SECS;
            st_o.sc_hours = 8'd0;
          end
        end
      end
      fcmc_pkg::KIND_LOCK: begin
        st_o.sleep_left = cfg.sleep_dly;
      end
      default: begin
        st_o = st_i;
      end
    endcase
  end

endmodule

[rtl/core/fcmc_ctrl.sv]
module fcmc_ctrl (
  input  fcmc_pkg::cfg_t   cfg,
  input  fcmc_pkg::state_t st_i,
  output fcmc_pkg::state_t st_o
);

  logic signed [7:0] on_thr;
  logic              cond_on;
  logic              cond_off;

  assign on_thr   = $signed({cfg.on_thr[6], cfg.on_thr});
  assign cond_on  = $signed(st_i.last_temp) >= on_thr;
  assign cond_off = $signed(st_i.last_temp) <= fcmc_pkg::off_temp(st_i.level);

  always_comb begin
    st_o = st_i;
    if (st_i.mode == fcmc_pkg::MODE_SUPER) begin
      // minute and hour bookkeeping
      if (st_o.sec_to_min == 6'd0) begin
        st_o.sc_min     = st_o.sc_min - 6'd1;
        st_o.sec_to_min = fcmc_pkg::MINUTE_SECS;
      end
      if (st_o.sc_min == 6'd0) begin
        st_o.sc_hours = st_o.sc_hours + 8'd1;
        st_o.sc_min   = fcmc_pkg::MINUTE_SECS;
      end
      if (st_o.sc_hours < cfg.hour_lim) begin
        st_o.want = 1'b1;
      end else begin
        st_o.want     = 1'b0;
        st_o.mode     = fcmc_pkg::MODE_LEVEL;
        st_o.sc_min   = fcmc_pkg::MINUTE_SECS;
        st_o.sc_hours = 8'd0;
      end
    end else begin
      // hysteresis thermostat
      if (cond_on) st_o.want = 1'b1;
      if (cond_off) st_o.want = 1'b0;
    end

    // compressor start delay sequencing
    if (st_o.want) begin
      if (st_o.phase == fcmc_pkg::PH_STOP) begin
        st_o.phase      = fcmc_pkg::PH_WAIT;
        st_o.delay_left = cfg.start_dly;
      end
      if (!st_o.drive && st_o.delay_left == 10'd0) begin
        st_o.phase = fcmc_pkg::PH_RUN;
        st_o.drive = 1'b1;
      end
    end else if (st_o.phase != fcmc_pkg::PH_STOP) begin
      st_o.phase = fcmc_pkg::PH_STOP;
      st_o.drive = 1'b0;
    end
  end

endmodule

[rtl/core/fcmc_checker.sv]
module fcmc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_compressor_drive,
  input logic [1:0] out_compressor_phase,
  input logic       out_cooling_mode,
  input logic [2:0] out_level_setting
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // drive only while running
  a_drive_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compressor_drive |-> out_compressor_phase == fcmc_pkg::PH_RUN)
    else $error("compressor driven outside run phase");

  // supercool always requests cooling
  a_super_cool: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cooling_mode == fcmc_pkg::MODE_SUPER
      |-> out_compressor_phase != fcmc_pkg::PH_STOP)
    else $error("supercool with compressor stopped");

  // level stays within the selectable range
  a_level_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level_setting >= fcmc_pkg::LEVEL_MIN &&
                  out_level_setting <= fcmc_pkg::LEVEL_MAX)
    else $error("level setting out of range");

  // no result right after reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind freezer_compressor_mode_controller_core fcmc_checker u_fcmc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_compressor_drive (out_compressor_drive),
  .out_compressor_phase (out_compressor_phase),
  .out_cooling_mode     (out_cooling_mode),
  .out_level_setting    (out_level_setting)
);

[tb/freezer_compressor_mode_controller_core_test.sv]
module freezer_compressor_mode_controller_core_test;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BATCH = 275;
  localparam logic [2:0] KIND_FIRST_SPARE = 3'd5;
  localparam logic [2:0] KIND_LAST_SPARE = 3'd7;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] temp;
    logic       held;
  } event_t;

  typedef struct packed {
    logic              drive;
    fcmc_pkg::phase_t  phase;
    logic              mode;
    logic [2:0]        level;
    logic              lock;
    logic              awake;
    logic [7:0]        leds;
  } status_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_kind = fcmc_pkg::KIND_TICK;
  logic [7:0] in_temperature = 8'h00;
  logic       in_lock_button_down = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_compressor_drive;
  logic [1:0] out_compressor_phase;
  logic       out_cooling_mode;
  logic [2:0] out_level_setting;
  logic       out_lock_active;
  logic       out_display_awake;
  logic [7:0] out_indicator_pattern;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = fcmc_pkg::CFG_ON_THR;
  logic [9:0] cfg_data = 10'd0;

  freezer_compressor_mode_controller_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_kind              (in_kind),
    .in_temperature       (in_temperature),
    .in_lock_button_down  (in_lock_button_down),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_compressor_drive (out_compressor_drive),
    .out_compressor_phase (out_compressor_phase),
    .out_cooling_mode     (out_cooling_mode),
    .out_level_setting    (out_level_setting),
    .out_lock_active      (out_lock_active),
    .out_display_awake    (out_display_awake),
    .out_indicator_pattern(out_indicator_pattern),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // Controller copy: configuration
  logic signed [6:0] thr_on;
  logic [7:0]        hour_limit;
  logic [9:0]        start_delay;
  logic [9:0]        sleep_delay;

  // Controller copy: state
  logic              pr_mode;
  logic [2:0]        pr_level;
  logic              pr_lock;
  logic              pr_want;
  fcmc_pkg::phase_t  pr_phase;
  logic              pr_drive;
  logic [9:0]        pr_delay;
  logic [9:0]        pr_sleep;
  logic [5:0]        pr_sec;
  logic [5:0]        pr_min;
  logic [7:0]        pr_hours;
  logic [1:0]        pr_hold;
  logic signed [7:0] pr_temp;

  event_t  event_queue[$];
  status_t status_due[$];
  int      error_count = 0;
  int      results_checked = 0;
  int      cycle_count = 0;
  int      holds_asked = 0;
  int      holds_served = 0;
  int      send_gap = 0;
  int      send_quiet = 0;
  int      recv_wait = 0;
  int      recv_quiet = 0;
  int      hold_left = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Pick an idle count; now and then start a stretch with no idling
  function automatic int draw_pause(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // Thermostat, supercool timer and compressor start logic, one pass
  function automatic void control_pass();
    int off_temp;
    if (pr_mode == fcmc_pkg::MODE_SUPER) begin
      if (pr_sec == 6'd0) begin
        pr_min = pr_min - 6'd1;
        pr_sec = fcmc_pkg::MINUTE_SECS;
      end
      if (pr_min == 6'd0) begin
        pr_hours = pr_hours + 8'd1;
        pr_min = fcmc_pkg::MINUTE_SECS;
      end
      if (pr_hours < hour_limit) begin
        pr_want = 1'b1;
      end else begin
        pr_want = 1'b0;
        pr_mode = fcmc_pkg::MODE_LEVEL;
        pr_min = fcmc_pkg::MINUTE_SECS;
        pr_hours = 8'd0;
      end
    end else begin
      case (pr_level)
        3'd1:    off_temp = -16;
        3'd2:    off_temp = -18;
        3'd4:    off_temp = -22;
        3'd5:    off_temp = -24;
        default: off_temp = -20;
      endcase
      if (pr_temp >= thr_on) pr_want = 1'b1;
      if (int'(pr_temp) <= off_temp) pr_want = 1'b0;
    end

    if (pr_want) begin
      if (pr_phase == fcmc_pkg::PH_STOP) begin
        pr_phase = fcmc_pkg::PH_WAIT;
        pr_delay = start_delay;
      end
      if (!pr_drive && pr_delay == 10'd0) begin
        pr_phase = fcmc_pkg::PH_RUN;
        pr_drive = 1'b1;
      end
    end else if (pr_phase != fcmc_pkg::PH_STOP) begin
      pr_phase = fcmc_pkg::PH_STOP;
      pr_drive = 1'b0;
    end
  endfunction

  // Apply one input word and return the status the block should report
  function automatic status_t advance_controller(event_t ev);
    status_t s;
    case (ev.kind)
      fcmc_pkg::KIND_TICK: begin
        if (pr_sleep != 10'd0) pr_sleep = pr_sleep - 10'd1;
        if (pr_sec != 6'd0) pr_sec = pr_sec - 6'd1;
        if (pr_delay != 10'd0 && pr_phase == fcmc_pkg::PH_WAIT) pr_delay = pr_delay - 10'd1;
        if (ev.held) begin
          if (pr_hold < fcmc_pkg::HOLD_TOGGLE) begin
            pr_hold = pr_hold + 2'd1;
            if (pr_hold == fcmc_pkg::HOLD_TOGGLE) begin
              pr_lock = ~pr_lock;
              pr_sleep = sleep_delay;
            end
          end
        end else begin
          pr_hold = 2'd0;
        end
      end
      fcmc_pkg::KIND_TEMP: pr_temp = ev.temp;
      fcmc_pkg::KIND_LEVEL, fcmc_pkg::KIND_SUPER: begin
        if (pr_sleep == 10'd0) begin
          pr_sleep = sleep_delay;
        end else if (!pr_lock) begin
          pr_sleep = sleep_delay;
          if (pr_mode == fcmc_pkg::MODE_SUPER) begin
            pr_mode = fcmc_pkg::MODE_LEVEL;
            pr_min = fcmc_pkg::MINUTE_SECS;
            pr_hours = 8'd0;
          end else if (ev.kind == fcmc_pkg::KIND_LEVEL) begin
            pr_level = (pr_level >= fcmc_pkg::LEVEL_MAX) ? fcmc_pkg::LEVEL_MIN
                                                         : pr_level + 3'd1;
          end else begin
            pr_mode = fcmc_pkg::MODE_SUPER;
            pr_min = fcmc_pkg::MINUTE_SECS;
            pr_hours = 8'd0;
          end
        end
      end
      fcmc_pkg::KIND_LOCK: pr_sleep = sleep_delay;
      default: ;
    endcase

    // the control logic settles in two passes
    control_pass();
    control_pass();

    s.drive = pr_drive;
    s.phase = pr_phase;
    s.mode = pr_mode;
    s.level = pr_level;
    s.lock = pr_lock;
    s.awake = (pr_sleep != 10'd0);
    if (pr_mode == fcmc_pkg::MODE_SUPER) begin
      s.leds = pr_lock ? fcmc_pkg::IND_SC_LOCKED : fcmc_pkg::IND_SC_UNLOCKED;
    end else begin
      case (pr_level)
        3'd1:    s.leds = pr_lock ? 8'hF6 : 8'hF3;
        3'd2:    s.leds = pr_lock ? 8'hEE : 8'hEB;
        3'd4:    s.leds = pr_lock ? 8'hBE : 8'hBB;
        3'd5:    s.leds = pr_lock ? 8'h7E : 8'h7B;
        default: s.leds = pr_lock ? 8'hDE : 8'hDB;
      endcase
    end
    return s;
  endfunction

  function automatic void push_event(logic [2:0] kind, logic [7:0] temp, logic held);
    event_t ev;
    ev.kind = kind;
    ev.temp = temp;
    ev.held = held;
    event_queue.push_back(ev);
  endfunction

  // Mostly near the thresholds, sometimes the extremes or anything
  function automatic logic [7:0] pick_temp();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom);
      1:       return $urandom_range(0, 1) ? 8'h7F : 8'h80;
      default: return 8'($urandom_range(0, 90) - 45);
    endcase
  endfunction

  function automatic void add_random_events(int count);
    int r;
    int n;
    logic [7:0] t;
    logic h;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      t = pick_temp();
      h = 1'($urandom_range(0, 1));
      if (r < 40) begin
        push_event(fcmc_pkg::KIND_TICK, t, 1'b0);
      end else if (r < 50) begin
        push_event(fcmc_pkg::KIND_TICK, t, h);
      end else if (r < 65) begin
        push_event(fcmc_pkg::KIND_TEMP, t, h);
      end else if (r < 75) begin
        push_event(fcmc_pkg::KIND_LEVEL, t, h);
      end else if (r < 82) begin
        push_event(fcmc_pkg::KIND_SUPER, t, h);
      end else if (r < 88) begin
        push_event(fcmc_pkg::KIND_LOCK, t, h);
      end else if (r < 91) begin
        push_event(3'($urandom_range(KIND_FIRST_SPARE, KIND_LAST_SPARE)), t, h);
      end else begin
        // hold the lock button long enough to toggle, then release
        n = $urandom_range(3, 4);
        repeat (n) push_event(fcmc_pkg::KIND_TICK, pick_temp(), 1'b1);
        push_event(fcmc_pkg::KIND_TICK, pick_temp(), 1'b0);
      end
    end
  endfunction

  task automatic report_error(string msg);
    if (error_count < 50) $display("ERROR at result %0d: %s", results_checked, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_error($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic write_reg(fcmc_pkg::cfg_idx_t idx, logic [9:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      fcmc_pkg::CFG_ON_THR:    thr_on = value[6:0];
      fcmc_pkg::CFG_HOUR_LIM:  hour_limit = value[7:0];
      fcmc_pkg::CFG_START_DLY: start_delay = value;
      fcmc_pkg::CFG_SLEEP_DLY: sleep_delay = value;
      default: ;
    endcase
  endtask

  task automatic set_registers(logic signed [6:0] on, logic [7:0] hrs, logic [9:0] st,
                               logic [9:0] sl);
    write_reg(fcmc_pkg::CFG_ON_THR, {3'b000, on});
    write_reg(fcmc_pkg::CFG_HOUR_LIM, {2'b00, hrs});
    write_reg(fcmc_pkg::CFG_START_DLY, st);
    write_reg(fcmc_pkg::CFG_SLEEP_DLY, sl);
    @(negedge clk);
  endtask

  // Wait until every word is sent and every status has come back
  task automatic settle();
    @(negedge clk);
    while (event_queue.size() != 0 || in_valid || status_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Driver: present queued words, idle a drawn number of cycles after each
  always @(posedge clk) begin
    event_t ev;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
      send_quiet = 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (event_queue.size() != 0) begin
        ev = event_queue.pop_front();
        in_valid <= 1'b1;
        in_kind <= ev.kind;
        in_temperature <= ev.temp;
        in_lock_button_down <= ev.held;
        send_gap = draw_pause(send_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: pause for a drawn idle count after each word, or hold off for a long stretch on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait = 0;
      recv_quiet = 0;
      hold_left = 0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served = holds_asked;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) recv_wait = draw_pause(recv_quiet);
      if (recv_wait != 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: check each status word, then predict for each accepted input word
  always @(posedge clk) begin
    status_t want;
    event_t ev;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (status_due.size() == 0) begin
          report_error("status word with nothing expected");
        end else begin
          want = status_due.pop_front();
          check_field("compressor_drive", out_compressor_drive, want.drive);
          check_field("compressor_phase", out_compressor_phase, want.phase);
          check_field("cooling_mode", out_cooling_mode, want.mode);
          check_field("level_setting", out_level_setting, want.level);
          check_field("lock_active", out_lock_active, want.lock);
          check_field("display_awake", out_display_awake, want.awake);
          check_field("indicator_pattern", out_indicator_pattern, want.leds);
        end
        results_checked++;
      end
      if (in_valid && in_ready) begin
        ev.kind = in_kind;
        ev.temp = in_temperature;
        ev.held = in_lock_button_down;
        status_due.push_back(advance_controller(ev));
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    thr_on = fcmc_pkg::ON_THR_RST;
    hour_limit = fcmc_pkg::HOUR_LIM_RST;
    start_delay = fcmc_pkg::START_DLY_RST;
    sleep_delay = fcmc_pkg::SLEEP_DLY_RST;
    pr_mode = fcmc_pkg::MODE_LEVEL;
    pr_level = fcmc_pkg::LEVEL_RST;
    pr_lock = 1'b0;
    pr_want = 1'b0;
    pr_phase = fcmc_pkg::PH_STOP;
    pr_drive = 1'b0;
    pr_delay = fcmc_pkg::START_DLY_RST;
    pr_sleep = fcmc_pkg::SLEEP_DLY_RST;
    pr_sec = fcmc_pkg::MINUTE_SECS;
    pr_min = fcmc_pkg::MINUTE_SECS;
    pr_hours = 8'd0;
    pr_hold = 2'd0;
    pr_temp = 8'sd0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: temperature extremes, level wrap, mode toggles, spare kinds,
    // lock hold past three ticks, locked press, press on a sleeping display
    set_registers(-7'sd40, 8'd1, 10'd0, 10'd2);
    push_event(fcmc_pkg::KIND_TEMP, 8'h7F, 1'b0);
    push_event(fcmc_pkg::KIND_TEMP, 8'h80, 1'b1);
    push_event(fcmc_pkg::KIND_TEMP, 8'h00, 1'b0);
    repeat (3) push_event(fcmc_pkg::KIND_LEVEL, 8'hFF, 1'b0);
    push_event(fcmc_pkg::KIND_SUPER, 8'h55, 1'b0);
    push_event(KIND_FIRST_SPARE, 8'hAA, 1'b1);
    push_event(fcmc_pkg::KIND_SUPER, 8'h00, 1'b0);
    push_event(KIND_LAST_SPARE, 8'hFF, 1'b1);
    repeat (4) push_event(fcmc_pkg::KIND_TICK, 8'h00, 1'b1);
    push_event(fcmc_pkg::KIND_LEVEL, 8'h00, 1'b0);
    repeat (3) push_event(fcmc_pkg::KIND_TICK, 8'hFF, 1'b0);
    push_event(fcmc_pkg::KIND_LEVEL, 8'h00, 1'b0);
    push_event(fcmc_pkg::KIND_LOCK, 8'h00, 1'b0);
    repeat (3) push_event(fcmc_pkg::KIND_TICK, 8'h00, 1'b1);
    push_event(fcmc_pkg::KIND_TICK, 8'h00, 1'b0);
    settle();

    // Hour limit of zero: supercool ends at once
    set_registers(7'sd0, 8'd0, 10'd1023, 10'd1023);
    push_event(fcmc_pkg::KIND_LOCK, 8'h00, 1'b0);
    push_event(fcmc_pkg::KIND_SUPER, 8'h00, 1'b0);
    push_event(fcmc_pkg::KIND_TICK, 8'h00, 1'b0);
    settle();

    // Sleep delay of zero: presses never act
    set_registers(7'sd40, 8'd255, 10'd5, 10'd0);
    repeat (3) push_event(fcmc_pkg::KIND_TICK, 8'h00, 1'b1);
    push_event(fcmc_pkg::KIND_TICK, 8'h00, 1'b0);
    push_event(fcmc_pkg::KIND_LEVEL, 8'h00, 1'b0);
    push_event(fcmc_pkg::KIND_SUPER, 8'h00, 1'b0);
    push_event(fcmc_pkg::KIND_LOCK, 8'h00, 1'b0);
    repeat (3) push_event(fcmc_pkg::KIND_TICK, 8'h00, 1'b1);
    push_event(fcmc_pkg::KIND_TICK, 8'h00, 1'b0);
    settle();

    // Random traffic over several settings, extremes included
    set_registers(fcmc_pkg::ON_THR_RST, fcmc_pkg::HOUR_LIM_RST, fcmc_pkg::START_DLY_RST,
                  fcmc_pkg::SLEEP_DLY_RST);
    add_random_events(RANDOM_BATCH);
    settle();
    set_registers(7'sd40, 8'd255, 10'd1023, 10'd1023);
    add_random_events(RANDOM_BATCH);
    settle();
    set_registers(-7'sd40, 8'd1, 10'd0, 10'd1);
    add_random_events(RANDOM_BATCH);
    settle();
    set_registers(7'($urandom_range(0, 80) - 40), 8'($urandom_range(1, 255)),
                  10'($urandom_range(0, 60)), 10'($urandom_range(1, 120)));
    add_random_events(RANDOM_BATCH);
    settle();

    // Hold off the receiver while words keep coming, so the input stalls
    set_registers(7'($urandom_range(0, 80) - 40), 8'($urandom_range(1, 255)),
                  10'($urandom_range(0, 60)), 10'($urandom_range(1, 120)));
    add_random_events(RANDOM_BATCH);
    holds_asked++;
    settle();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[freezer_compressor_mode_controller_core.f]
rtl/core/fcmc_pkg.sv
rtl/core/fcmc_event.sv
rtl/core/fcmc_ctrl.sv
rtl/core/freezer_compressor_mode_controller_core.sv
rtl/core/fcmc_checker.sv
tb/freezer_compressor_mode_controller_core_test.sv
